// ----- rtl/tbq_pkg.sv -----
package tbq_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int STAGE_COUNT = 3;

  localparam int FF_W      = 21;
  localparam int FB_W      = 32;
  localparam int DELAY_W   = 48;
  localparam int FF_FRAC   = 19;
  localparam int FB_FRAC   = 30;
  localparam int RND_SH    = FB_FRAC - FF_FRAC;
  localparam int FFREG_W   = 3 * FF_W;
  localparam int FBREG_W   = 2 * FB_W;
  localparam int CFG_DATA_W = 64;
  localparam int REG_COUNT = 2 * STAGE_COUNT;
  localparam int CFG_IDX_W = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1;

  localparam int PROD_W = FB_W + SAMPLE_W;
  localparam int SUM_W  = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 2;

  localparam logic [FFREG_W-1:0] FF_RESET = FFREG_W'(1) << FF_FRAC;

  localparam logic signed [SUM_W-1:0] RND_Y  = SUM_W'(1) << (FF_FRAC - 1);
  localparam logic signed [SUM_W-1:0] RND_FB = SUM_W'(1) << (RND_SH - 1);

  localparam logic signed [SUM_W-1:0] SMP_MAX =
    {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [SUM_W-1:0] DLY_MAX =
    {{(SUM_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DLY_MIN = ~DLY_MAX;

  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] smp;
  } cell_link_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v);
    if (v > SMP_MAX) return SMP_MAX[SAMPLE_W-1:0];
    if (v < SMP_MIN) return SMP_MIN[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(
    input logic signed [SUM_W-1:0] v);
    if (v > DLY_MAX) return DLY_MAX[DELAY_W-1:0];
    if (v < DLY_MIN) return DLY_MIN[DELAY_W-1:0];
    return v[DELAY_W-1:0];
  endfunction

endpackage

// ----- rtl/tbq_cell.sv -----
module tbq_cell
  import tbq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_link_t         link_in,
  input  logic [FFREG_W-1:0] ff_coef,
  input  logic [FBREG_W-1:0] fb_coef,
  output cell_link_t         link_out
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_Y    = 3'd1;
  localparam logic [2:0] ST_T1   = 3'd2;
  localparam logic [2:0] ST_T2   = 3'd3;
  localparam logic [2:0] ST_Z1   = 3'd4;
  localparam logic [2:0] ST_Z2   = 3'd5;

  logic [2:0]                step_r, step_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [SUM_W-1:0]    t1_r, t1_nxt;
  logic signed [PROD_W-1:0]   t2_r, t2_nxt;
  logic signed [DELAY_W-1:0]  z1_r, z1_nxt;
  logic signed [DELAY_W-1:0]  z2_r, z2_nxt;

  logic signed [FF_W-1:0]     b0, b1, b2;
  logic signed [FB_W-1:0]     a1, a2;
  logic signed [FB_W-1:0]     mul_coef;
  logic signed [SAMPLE_W-1:0] mul_smp;
  logic signed [SUM_W-1:0]    y_sum, y_shift, fb_rnd;

  assign b0 = ff_coef[FF_W-1:0];
  assign b1 = ff_coef[2*FF_W-1:FF_W];
  assign b2 = ff_coef[3*FF_W-1:2*FF_W];
  assign a1 = fb_coef[FB_W-1:0];
  assign a2 = fb_coef[2*FB_W-1:FB_W];

  assign y_sum   = SUM_W'(prod_r) + SUM_W'(z1_r) + RND_Y;
  assign y_shift = y_sum >>> FF_FRAC;
  assign fb_rnd  = (SUM_W'(prod_r) + RND_FB) >>> RND_SH;

  always_comb begin
    mul_coef = {{(FB_W - FF_W){b0[FF_W-1]}}, b0};
    mul_smp  = link_in.smp;
    case (step_r)
      ST_IDLE: begin
        mul_coef = {{(FB_W - FF_W){b0[FF_W-1]}}, b0};
        mul_smp  = link_in.smp;
      end
      ST_Y: begin
        mul_coef = {{(FB_W - FF_W){b1[FF_W-1]}}, b1};
        mul_smp  = x_r;
      end
      ST_T1: begin
        mul_coef = {{(FB_W - FF_W){b2[FF_W-1]}}, b2};
        mul_smp  = x_r;
      end
      ST_T2: begin
        mul_coef = a1;
        mul_smp  = y_r;
      end
      ST_Z1: begin
        mul_coef = a2;
        mul_smp  = y_r;
      end
      default: begin
        mul_coef = a2;
        mul_smp  = y_r;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    prod_nxt = prod_r;
    t1_nxt   = t1_r;
    t2_nxt   = t2_r;
    z1_nxt   = z1_r;
    z2_nxt   = z2_r;
    case (step_r)
      ST_IDLE: begin
        if (link_in.vld) begin
          x_nxt    = link_in.smp;
          prod_nxt = mul_coef * mul_smp;
          step_nxt = ST_Y;
        end
      end
      ST_Y: begin
        y_nxt    = sat_sample(y_shift);
        prod_nxt = mul_coef * mul_smp;
        step_nxt = ST_T1;
      end
      ST_T1: begin
        t1_nxt   = SUM_W'(prod_r) + SUM_W'(z2_r);
        prod_nxt = mul_coef * mul_smp;
        step_nxt = ST_T2;
      end
      ST_T2: begin
        t2_nxt   = prod_r;
        prod_nxt = mul_coef * mul_smp;
        step_nxt = ST_Z1;
      end
      ST_Z1: begin
        z1_nxt   = sat_delay(t1_r - fb_rnd);
        prod_nxt = mul_coef * mul_smp;
        step_nxt = ST_Z2;
      end
      ST_Z2: begin
        z2_nxt   = sat_delay(SUM_W'(t2_r) - fb_rnd);
        step_nxt = ST_IDLE;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      z1_r   <= '0;
      z2_r   <= '0;
    end else begin
      step_r <= step_nxt;
      z1_r   <= z1_nxt;
      z2_r   <= z2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
  end

  assign link_out.vld = (step_r == ST_Z2);
  assign link_out.smp = y_r;

endmodule

// ----- rtl/three_band_biquad_eq_core.sv -----
// Each stage cell steps its single multiplier through five products, one cell
// after another; a new sample is taken only once the last cell has finished.
// A result can wait in the output register while the next sample runs; that
// sample's result then waits in a second slot, and input stalls until it moves on.
// Reset (synchronous, rst_n low) clears all delay words, the handshake state
// and returns coefficients to pass-through (b0 = 1.0, all others zero).
module three_band_biquad_eq_core
  import tbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [FFREG_W-1:0] ff_r [STAGE_COUNT];
  logic [FBREG_W-1:0] fb_r [STAGE_COUNT];

  cell_link_t links [STAGE_COUNT+1];

  logic                       busy_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_smp_r;
  logic                       pend_valid_r;
  logic signed [SAMPLE_W-1:0] pend_smp_r;
  logic                       in_xfer, out_xfer, done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGE_COUNT; s++) begin
        ff_r[s] <= FF_RESET;
        fb_r[s] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int s = 0; s < STAGE_COUNT; s++) begin
        if (cfg_index == CFG_IDX_W'(2 * s)) begin
          ff_r[s] <= cfg_data[FFREG_W-1:0];
        end
        if (cfg_index == CFG_IDX_W'(2 * s + 1)) begin
          fb_r[s] <= cfg_data[FBREG_W-1:0];
        end
      end
    end
  end

  assign in_stall = busy_r | pend_valid_r;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;
  assign done     = links[STAGE_COUNT].vld;

  assign links[0].vld = in_xfer;
  assign links[0].smp = in_sample_in;

  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
    tbq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (links[g]),
      .ff_coef  (ff_r[g]),
      .fb_coef  (fb_r[g]),
      .link_out (links[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        if (out_valid_r && !out_xfer) begin
          pend_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_r  <= pend_valid_r;
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (out_valid_r && !out_xfer) begin
        pend_smp_r <= links[STAGE_COUNT].smp;
      end else begin
        out_smp_r <= links[STAGE_COUNT].smp;
      end
    end else if (out_xfer && pend_valid_r) begin
      out_smp_r <= pend_smp_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_smp_r;

endmodule

// ----- rtl/tbq_checker.sv -----
module tbq_checker
  import tbq_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] in_sample_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_sample_out,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_IDX_W-1:0]       cfg_index,
  input logic [CFG_DATA_W-1:0]      cfg_data
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared right after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled output changed");

endmodule

bind three_band_biquad_eq_core tbq_checker u_tbq_checker (.*);

// ----- tb/sv/tb_three_band_biquad_eq_core.sv -----
module tb_three_band_biquad_eq_core;
  import tbq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int LATENCY     = 5 * STAGE_COUNT;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_FF,
    REG_LOW_FB,
    REG_MID_FF,
    REG_MID_FB,
    REG_HIGH_FF,
    REG_HIGH_FB,
    REG_SPARE_A,
    REG_SPARE_B
  } eq_reg_t;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam int COEF_FF_MAX = (1 << (FF_W - 1)) - 1;
  localparam int COEF_FF_MIN = -(1 << (FF_W - 1));

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  logic [CFG_DATA_W-1:0]      band_coef [REG_COUNT];
  longint                     band_delay [REG_COUNT];
  logic signed [SAMPLE_W-1:0] pending_out_q [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_max    = 8;
  int rx_idle_max    = 8;
  int rx_hold_cycles = 0;

  three_band_biquad_eq_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint round_drop(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // advance the three biquads by one sample and return the equalized output
  function automatic logic signed [SAMPLE_W-1:0] eq_filter_sample(
    input logic signed [SAMPLE_W-1:0] smp);
    longint x;
    longint y;
    longint b0, b1, b2, a1, a2;
    longint fb1, fb2;
    logic [CFG_DATA_W-1:0] ff;
    logic [CFG_DATA_W-1:0] fb;
    int s;
    x = smp;
    for (s = 0; s < STAGE_COUNT; s++) begin
      ff = band_coef[2 * s];
      fb = band_coef[2 * s + 1];
      b0 = longint'($signed(ff[FF_W-1:0]));
      b1 = longint'($signed(ff[2*FF_W-1:FF_W]));
      b2 = longint'($signed(ff[3*FF_W-1:2*FF_W]));
      a1 = longint'($signed(fb[FB_W-1:0]));
      a2 = longint'($signed(fb[2*FB_W-1:FB_W]));
      y = clamp_to(round_drop(b0 * x + band_delay[2 * s], FF_FRAC), SAMPLE_W);
      fb1 = round_drop(a1 * y, RND_SH);
      fb2 = round_drop(a2 * y, RND_SH);
      band_delay[2 * s]     = clamp_to(b1 * x - fb1 + band_delay[2 * s + 1], DELAY_W);
      band_delay[2 * s + 1] = clamp_to(b2 * x - fb2, DELAY_W);
      x = y;
    end
    return x[SAMPLE_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] ff_word(input int b0, input int b1, input int b2);
    return {1'b0, b2[FF_W-1:0], b1[FF_W-1:0], b0[FF_W-1:0]};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] fb_word(input int a1, input int a2);
    return {a2[FB_W-1:0], a1[FB_W-1:0]};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [31:0] r;
    r = $signed($urandom);
    case ($urandom_range(9, 0))
      0: return r[SAMPLE_W-1:0];
      1: return SAMPLE_MAX;
      2: return SAMPLE_MIN;
      default: begin
        r = r >>> $urandom_range(20, 8);
        return r[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_sample_out);
        mismatch_count++;
      end else begin
        want = pending_out_q.pop_front();
        if (out_sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, want, out_sample_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = $urandom_range(rx_idle_max, 0);
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = $urandom_range(tx_idle_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample_in = smp;
    do @(posedge clk); while (in_stall);
    pending_out_q.push_back(eq_filter_sample(smp));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input eq_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (int'(idx) < REG_COUNT) begin
      band_coef[idx] = (int'(idx) % 2 == 0) ? {1'b0, data[FFREG_W-1:0]} : data;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_random_setting();
    int s;
    int b0, b1, b2, a1, a2;
    for (s = 0; s < STAGE_COUNT; s++) begin
      if ($urandom_range(3, 0) == 0) begin
        write_coef(eq_reg_t'(2 * s), {$urandom, $urandom});
        write_coef(eq_reg_t'(2 * s + 1), {$urandom, $urandom});
      end else begin
        b0 = $signed($urandom) >>> 12;
        b1 = $signed($urandom) >>> 12;
        b2 = $signed($urandom) >>> 13;
        a1 = $signed($urandom) >>> 2;
        a2 = $signed($urandom) >>> 3;
        write_coef(eq_reg_t'(2 * s), ff_word(b0, b1, b2));
        write_coef(eq_reg_t'(2 * s + 1), fb_word(a1, a2));
      end
    end
  endtask

  task automatic test_reset_passthrough();
    int i;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    for (i = 0; i < REG_COUNT; i++) begin
      band_coef[i]  = (i % 2 == 0) ? CFG_DATA_W'(FF_RESET) : '0;
      band_delay[i] = 0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-1));
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_coef(REG_LOW_FF, '1);
    write_coef(REG_LOW_FB, {32'h7FFF_FFFF, 32'h8000_0000});
    write_coef(REG_MID_FF, ff_word(COEF_FF_MAX, COEF_FF_MIN, COEF_FF_MAX));
    write_coef(REG_MID_FB, {32'h8000_0000, 32'h7FFF_FFFF});
    write_coef(REG_HIGH_FF, 64'h8000_0000_0008_0000);
    write_coef(REG_HIGH_FB, '0);
    write_coef(REG_SPARE_A, {$urandom, $urandom});
    write_coef(REG_SPARE_B, '1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_W'(-1));
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
  endtask

  task automatic test_output_saturation();
    wait_idle();
    write_coef(REG_LOW_FF, ff_word(COEF_FF_MAX, 0, 0));
    write_coef(REG_LOW_FB, '0);
    write_coef(REG_MID_FF, ff_word(COEF_FF_MAX, 0, 0));
    write_coef(REG_MID_FB, '0);
    write_coef(REG_HIGH_FF, ff_word(COEF_FF_MIN, 0, 0));
    write_coef(REG_HIGH_FB, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'h400000);
    send_sample(24'hBFFFFF);
    send_sample('0);
    send_sample(SAMPLE_W'(1));
  endtask

  task automatic test_random_settings();
    int phase;
    int i;
    for (phase = 0; phase < 5; phase++) begin
      wait_idle();
      load_random_setting();
      for (i = 0; i < 66; i++) send_sample(rand_sample());
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    wait_idle();
    tx_idle_max    = 0;
    rx_hold_cycles = 400;
    for (i = 0; i < 30; i++) send_sample(rand_sample());
    tx_idle_max = 8;
  endtask

  task automatic test_drain_pause_and_full_rate();
    int i;
    for (i = 0; i < 20; i++) send_sample(rand_sample());
    wait_idle();
    tx_idle_max = 0;
    rx_idle_max = 0;
    for (i = 0; i < 20; i++) send_sample(rand_sample());
    tx_idle_max = 8;
    rx_idle_max = 8;
  endtask

  initial begin
    test_reset_passthrough();
    test_register_extremes();
    test_output_saturation();
    test_random_settings();
    test_output_backpressure();
    test_drain_pause_and_full_rate();
    wait_idle();
    repeat (2 * LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tbq_pkg.sv
rtl/tbq_cell.sv
rtl/three_band_biquad_eq_core.sv
rtl/tbq_checker.sv
tb/sv/tb_three_band_biquad_eq_core.sv
